[sv/cascade_pid_with_antiwindup_macros.svh]
// ----------------------------------------------------------------------------
// Cascade PID assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef CASCADE_PID_WITH_ANTIWINDUP_MACROS_SVH
`define CASCADE_PID_WITH_ANTIWINDUP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CPWA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cascade pid check failed");

// next-cycle implication, disabled in reset
`define CPWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cascade pid check failed");

`endif

[sv/cpwa_pkg.sv]
// ----------------------------------------------------------------------------
// Cascade PID package
// Widths, constants, sequencer steps and helpers shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none
package cpwa_pkg;

   localparam int AW = 40;        // operand magnitude width
   localparam int BW = 32;        // multiplier magnitude width
   localparam int DW = 20;        // divisor width
   localparam int PW = AW + BW;   // product width
   localparam int RW = PW + 1;    // signed result width
   localparam int SW = PW + 4;    // working sum width

   localparam int RATIO_NUM   = 192037;
   localparam int RATIO_DEN   = 10000;
   localparam int US_PER_S    = 1000000;
   localparam int DT_MIN_US   = 100;
   localparam int INTEG_LIMIT = 2000;
   localparam int OUT_CLAMP   = 16384;
   localparam int NUM_REGS    = 6;

   localparam logic [2:0] REG_ANGLE_P = 3'd0;
   localparam logic [2:0] REG_SPEED_P = 3'd3;

   localparam logic signed [SW-1:0] S32_MAX = SW'(32'sh7FFFFFFF);
   localparam logic signed [SW-1:0] S32_MIN = SW'(32'sh80000000);

   typedef struct packed {
      logic          neg;
      logic [AW-1:0] a;
      logic [BW-1:0] b;
      logic          div;
      logic [DW-1:0] d;
   } mdu_cmd_type;

   typedef enum logic [7:0] {
      ST_OUTER_TGT = 8'b0000_0001,
      ST_INTEG     = 8'b0000_0010,
      ST_DERIV     = 8'b0000_0100,
      ST_TERM_P    = 8'b0000_1000,
      ST_TERM_I    = 8'b0001_0000,
      ST_TERM_D    = 8'b0010_0000,
      ST_INNER_TGT = 8'b0100_0000,
      ST_INNER_CUR = 8'b1000_0000
   } step_type;

   function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = 32'sh7FFFFFFF;
      else if (v < S32_MIN) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [AW-1:0] mag(input logic signed [AW:0] v);
      logic signed [AW:0] t;
      t = v[AW] ? -v : v;
      return t[AW-1:0];
   endfunction

endpackage
`default_nettype wire

[sv/cpwa_mdu.sv]
// ----------------------------------------------------------------------------
// Cascade PID multiply-divide unit
// Bit-serial shift-add multiply, then optional restoring floor divide.
// ----------------------------------------------------------------------------
`default_nettype none
module cpwa_mdu
   import cpwa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire mdu_cmd_type          cmd,
   output logic                      done,
   output logic signed [RW-1:0]      result
);

   localparam int CW = $clog2(PW + 1);

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_MUL  = 4'b0010,
      M_DIV  = 4'b0100,
      M_FIN  = 4'b1000
   } mdu_state_type;

   mdu_state_type state_ff, state_in;
   logic [PW-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [BW-1:0] mplier_ff, mplier_in;
   logic [DW-1:0] rem_ff, rem_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, div_ff, div_in, done_ff, done_in;
   logic signed [RW-1:0] result_ff, result_in;
   logic [DW:0] trial, diff;
   logic ge;
   logic [RW-1:0] qmag;

   always_comb begin
      trial = {rem_ff, acc_ff[PW-1]};
      diff  = trial - {1'b0, d_ff};
      ge    = trial >= {1'b0, d_ff};
      qmag  = {1'b0, acc_ff} + RW'(neg_ff && div_ff && (rem_ff != '0));
      state_in  = state_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      div_in    = div_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               acc_in    = '0;
               mcand_in  = PW'(cmd.a);
               mplier_in = cmd.b;
               neg_in    = cmd.neg;
               div_in    = cmd.div;
               d_in      = cmd.d;
               rem_in    = '0;
               cnt_in    = CW'(PW);
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            if (mplier_ff == '0) begin
               state_in = div_ff ? M_DIV : M_FIN;
            end else begin
               if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         M_DIV: begin
            // one quotient bit per cycle, shifted into the low end
            acc_in = {acc_ff[PW-2:0], ge};
            rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) state_in = M_FIN;
         end
         M_FIN: begin
            // apply the sign; floor for negative quotients: round the magnitude up on a remainder
            result_in = neg_ff ? -$signed(qmag) : $signed(qmag);
            done_in   = 1'b1;
            state_in  = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      div_ff    <= div_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
`default_nettype wire

[sv/cascade_pid_with_antiwindup.sv]
// Each sample takes seven multiply-divide steps (multiply, divide, handoff)
//   and six gain multiplies from input transfer to result; the block takes
//   one sample at a time.
// The serial multiply-divide unit sets the rate; a multiply ends early once
//   the remaining multiplier bits are zero.
// Reset: synchronous, clears gains, integrals, last errors and handshakes.
// ----------------------------------------------------------------------------
// Cascade PID with anti-windup
// Outer angle loop feeding an inner speed loop through a geared motor ratio,
// fixed point, evaluated by a sequencer around one bit-serial arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
module cascade_pid_with_antiwindup
   import cpwa_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // rotor_target_angle[31:0], wheel_angle[63:32], wheel_speed[95:64],
   // dt_us[115:96], zero fill above
   input  wire logic [119:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // drive_current[15:0], speed_target[31:16], angle_saturated[32],
   // speed_saturated[33], zero fill above
   output logic [39:0]        rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   localparam logic signed [SW-1:0] ILIM = SW'(INTEG_LIMIT) <<< FRAC_BITS;
   localparam logic signed [SW-1:0] OLIM = SW'(OUT_CLAMP) <<< FRAC_BITS;

   typedef enum logic [3:0] {
      T_IDLE  = 4'b0001,
      T_ISSUE = 4'b0010,
      T_WAIT  = 4'b0100,
      T_OUT   = 4'b1000
   } top_state_type;

   // integer part of a loop output, truncated toward zero
   function automatic logic [15:0] ipart(input logic signed [AW-1:0] v);
      logic [AW-1:0] m;
      logic [AW-1:0] s;
      m = mag({v[AW-1], v});
      s = m >> FRAC_BITS;
      return v[AW-1] ? 16'(-s) : s[15:0];
   endfunction

   top_state_type state_ff, state_in;
   step_type step_ff, step_in;
   logic loop_ff, loop_in;
   logic signed [31:0] gain_ff [NUM_REGS];
   logic signed [31:0] integ_ff [2], integ_in [2];
   logic signed [31:0] last_ff [2], last_in [2];
   logic signed [31:0] rotor_ff, rotor_in, wangle_ff, wangle_in, wspeed_ff, wspeed_in;
   logic [DW-1:0] dt_ff, dt_in;
   logic signed [31:0] tgt_ff, tgt_in, cur_ff, cur_in, ni_ff, ni_in, der_ff, der_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [AW-1:0] outer_ff, outer_in;
   logic [15:0] drive_ff, drive_in;
   logic asat_ff, asat_in, ssat_ff, ssat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic signed [31:0] err, gsel, xsel;
   logic signed [32:0] diff;
   logic [2:0] gidx;
   mdu_cmd_type cmd;
   logic mdu_start, mdu_done;
   logic signed [RW-1:0] res;
   logic signed [SW-1:0] term, ni_sum, out_sum, out_clamped;
   logic signed [31:0] ni_sat, ni_clamped;
   logic out_sat;
   logic [DW-1:0] dt_raw;

   cpwa_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (mdu_start),
      .cmd    (cmd),
      .done   (mdu_done),
      .result (res)
   );

   assign req_tready = (state_ff == T_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign mdu_start  = (state_ff == T_ISSUE);
   assign dt_raw     = req_tdata[115:96];

   // operands of the current step
   always_comb begin
      err  = sat32(SW'(tgt_ff) - SW'(cur_ff));
      diff = {err[31], err} - {last_ff[loop_ff][31], last_ff[loop_ff]};
      case (step_ff)
         ST_TERM_I: gidx = 3'd1;
         ST_TERM_D: gidx = 3'd2;
         default:   gidx = 3'd0;
      endcase
      gidx = gidx + (loop_ff ? REG_SPEED_P : REG_ANGLE_P);
      gsel = gain_ff[gidx];
      case (step_ff)
         ST_TERM_I: xsel = ni_ff;
         ST_TERM_D: xsel = der_ff;
         default:   xsel = err;
      endcase
      cmd.neg = gsel[31] ^ xsel[31];
      cmd.a   = mag((AW+1)'(xsel));
      cmd.b   = BW'(mag((AW+1)'(gsel)));
      cmd.div = 1'b0;
      cmd.d   = DW'(US_PER_S);
      case (step_ff)
         ST_OUTER_TGT: begin
            cmd.neg = rotor_ff[31];
            cmd.a   = mag((AW+1)'(rotor_ff));
            cmd.b   = BW'(RATIO_DEN);
            cmd.div = 1'b1;
            cmd.d   = DW'(RATIO_NUM);
         end
         ST_INTEG: begin
            cmd.neg = err[31];
            cmd.a   = mag((AW+1)'(err));
            cmd.b   = BW'(dt_ff);
            cmd.div = 1'b1;
            cmd.d   = DW'(US_PER_S);
         end
         ST_DERIV: begin
            cmd.neg = diff[32];
            cmd.a   = mag((AW+1)'(diff));
            cmd.b   = BW'(US_PER_S);
            cmd.div = 1'b1;
            cmd.d   = dt_ff;
         end
         ST_INNER_TGT: begin
            cmd.neg = outer_ff[AW-1];
            cmd.a   = mag({outer_ff[AW-1], outer_ff});
            cmd.b   = BW'(RATIO_NUM);
            cmd.div = 1'b1;
            cmd.d   = DW'(RATIO_DEN);
         end
         ST_INNER_CUR: begin
            cmd.neg = wspeed_ff[31];
            cmd.a   = mag((AW+1)'(wspeed_ff));
            cmd.b   = BW'(RATIO_NUM);
            cmd.div = 1'b1;
            cmd.d   = DW'(RATIO_DEN);
         end
         default: ;
      endcase
   end

   // result post-processing
   always_comb begin
      term    = SW'(res >>> FRAC_BITS);
      ni_sum  = SW'(integ_ff[loop_ff]) + SW'(res);
      ni_sat  = sat32(ni_sum);
      if (SW'(ni_sat) > ILIM) ni_clamped = ILIM[31:0];
      else if (SW'(ni_sat) < -ILIM) ni_clamped = 32'(-ILIM);
      else ni_clamped = ni_sat;
      out_sum = sum_ff + term;
      out_sat = (out_sum > OLIM) || (out_sum < -OLIM);
      if (out_sum > OLIM) out_clamped = OLIM;
      else if (out_sum < -OLIM) out_clamped = -OLIM;
      else out_clamped = out_sum;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      loop_in      = loop_ff;
      integ_in     = integ_ff;
      last_in      = last_ff;
      rotor_in     = rotor_ff;
      wangle_in    = wangle_ff;
      wspeed_in    = wspeed_ff;
      dt_in        = dt_ff;
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      ni_in        = ni_ff;
      der_in       = der_ff;
      sum_in       = sum_ff;
      outer_in     = outer_ff;
      drive_in     = drive_ff;
      asat_in      = asat_ff;
      ssat_in      = ssat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         T_IDLE: begin
            if (req_tvalid) begin
               // latch the sample, clamp short periods
               rotor_in  = req_tdata[31:0];
               wangle_in = req_tdata[63:32];
               wspeed_in = req_tdata[95:64];
               dt_in     = (dt_raw < DW'(DT_MIN_US)) ? DW'(DT_MIN_US) : dt_raw;
               step_in   = ST_OUTER_TGT;
               loop_in   = 1'b0;
               state_in  = T_ISSUE;
            end
         end
         T_ISSUE: state_in = T_WAIT;
         T_WAIT: begin
            if (mdu_done) begin
               state_in = T_ISSUE;
               case (step_ff)
                  ST_OUTER_TGT: begin
                     tgt_in  = sat32(SW'(res));
                     cur_in  = wangle_ff;
                     step_in = ST_INTEG;
                  end
                  ST_INTEG: begin
                     ni_in   = ni_clamped;
                     step_in = ST_DERIV;
                  end
                  ST_DERIV: begin
                     der_in  = sat32(SW'(res));
                     step_in = ST_TERM_P;
                  end
                  ST_TERM_P: begin
                     sum_in  = term;
                     step_in = ST_TERM_I;
                  end
                  ST_TERM_I: begin
                     sum_in  = out_sum;
                     step_in = ST_TERM_D;
                  end
                  ST_TERM_D: begin
                     // anti-windup: drop this sample's integral step on clamp
                     integ_in[loop_ff] = out_sat ? integ_ff[loop_ff] : ni_ff;
                     last_in[loop_ff]  = err;
                     if (!loop_ff) begin
                        outer_in = out_clamped[AW-1:0];
                        asat_in  = out_sat;
                        step_in  = ST_INNER_TGT;
                     end else begin
                        drive_in = ipart(out_clamped[AW-1:0]);
                        ssat_in  = out_sat;
                        state_in = T_OUT;
                     end
                  end
                  ST_INNER_TGT: begin
                     tgt_in  = sat32(SW'(res));
                     step_in = ST_INNER_CUR;
                  end
                  ST_INNER_CUR: begin
                     cur_in  = sat32(SW'(res));
                     loop_in = 1'b1;
                     step_in = ST_INTEG;
                  end
                  default: state_in = T_IDLE;
               endcase
            end
         end
         T_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, ssat_ff, asat_ff, ipart(outer_ff), drive_ff};
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= ST_OUTER_TGT;
         loop_ff      <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) gain_ff[i] <= '0;
         for (int i = 0; i < 2; i++) begin
            integ_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         loop_ff      <= loop_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
         // configuration transfer; indexes past the list are dropped
         if (csr_valid && (int'(csr_index) < NUM_REGS)) gain_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rotor_ff    <= rotor_in;
      wangle_ff   <= wangle_in;
      wspeed_ff   <= wspeed_in;
      dt_ff       <= dt_in;
      tgt_ff      <= tgt_in;
      cur_ff      <= cur_in;
      ni_ff       <= ni_in;
      der_ff      <= der_in;
      sum_ff      <= sum_in;
      outer_ff    <= outer_in;
      drive_ff    <= drive_in;
      asat_ff     <= asat_in;
      ssat_ff     <= ssat_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

[sv/cpwa_checker.sv]
// ----------------------------------------------------------------------------
// Cascade PID port checker
// Watches the result channel for hold, range and saturation consistency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascade_pid_with_antiwindup_macros.svh"
module cpwa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   `CPWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CPWA_ASSERT_IMPL(a_drive_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[15:0]) >= -16384) && ($signed(rsp_tdata[15:0]) <= 16384))
   `CPWA_ASSERT_IMPL(a_angle_sat, clock, reset, rsp_tvalid && rsp_tdata[32], (rsp_tdata[31:16] == 16'h4000) || (rsp_tdata[31:16] == 16'hC000))
   `CPWA_ASSERT_IMPL(a_speed_sat, clock, reset, rsp_tvalid && rsp_tdata[33], (rsp_tdata[15:0] == 16'h4000) || (rsp_tdata[15:0] == 16'hC000))

endmodule

bind cascade_pid_with_antiwindup cpwa_checker u_cpwa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
